[rtl/lnfa_pkg.sv]
// lnfa_pkg: shared constants and codes of the lambda nfa word acceptor
// default sizes, the lambda symbol code, command and register codes
// no dependencies
package lnfa_pkg;

  localparam int NUM_STATES_DEF  = 16;
  localparam int SYMBOL_BITS_DEF = 8;

  // character code of the lambda symbol
  localparam logic [7:0] LAMBDA_CODE = 8'd46;

  typedef enum logic [1:0] {
    CMD_ADD_TRANS = 2'd0,
    CMD_ADD_SYM   = 2'd1,
    CMD_WORD      = 2'd2
  } cmd_t;

  // register index as decoded from the byte address
  localparam logic REG_START_STATE = 1'b0;
  localparam logic REG_ACCEPT_MASK = 1'b1;

endpackage

[rtl/lnfa_tbl.sv]
// lnfa_tbl: memory with one write and one read port, registered read
// holds the transition table or the alphabet map; sweeps every entry to zero after reset
// and flags it while doing so; no dependencies
module lnfa_tbl #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  output logic                 clearing
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [ADDR_BITS-1:0] clr_cnt_r;
  logic                 clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign clearing = clr_r;

endmodule

[rtl/lambda_nfa_word_acceptor.sv]
// lambda_nfa_word_acceptor: nfa with lambda moves, active states kept as a bit set
// a load word writes the alphabet map directly, or the transition table by read-modify-write
// a word symbol reads at most 3*NUM_STATES table rows: lambda closure of the start state
// when opening a word, then the symbol step and its lambda closure; outside the alphabet
// or on an empty set no step; result strobe as busy falls, the cycle after the finish state
// the receiver cannot stall; after reset busy stays high while the memories clear
module lambda_nfa_word_acceptor #(
  parameter int NUM_STATES  = lnfa_pkg::NUM_STATES_DEF,
  parameter int SYMBOL_BITS = lnfa_pkg::SYMBOL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_from_state,
  input  logic [7:0]  in_symbol,
  input  logic [3:0]  in_to_state,
  input  logic        in_last,
  output logic        out_valid,
  output logic        out_accepted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SIDX      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int AW        = SIDX + SYMBOL_BITS;
  localparam logic [SYMBOL_BITS-1:0] LAMBDA_SYM = SYMBOL_BITS'(lnfa_pkg::LAMBDA_CODE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_WORD_CHK,
    ST_GATHER_ISSUE,
    ST_GATHER_WAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_STEP,
    PH_CLOSE
  } phase_t;

  state_t                  state_r;
  phase_t                  phase_r;
  logic                    in_word_r;
  logic                    out_valid_r;
  logic                    out_accepted_r;
  logic [3:0]              start_state_r;
  logic [15:0]             accept_mask_r;
  logic [NUM_STATES-1:0]   set_r;
  logic [NUM_STATES-1:0]   src_r;
  logic [NUM_STATES-1:0]   done_r;
  logic [NUM_STATES-1:0]   to_oh_r;
  logic [AW-1:0]           waddr_r;
  logic [SYMBOL_BITS-1:0]  sym_r;
  logic                    last_r;

  logic                    accept;
  logic                    tbl_clr;
  logic                    tbl_rd_en;
  logic [AW-1:0]           tbl_rd_addr;
  logic [NUM_STATES-1:0]   tbl_rdata;
  logic                    tbl_wr_en;
  logic [NUM_STATES-1:0]   tbl_wr_data;
  logic                    alpha_clr;
  logic                    alpha_rd_en;
  logic                    alpha_rdata;
  logic                    alpha_wr_en;
  logic [SYMBOL_BITS-1:0]  in_sym;
  logic                    trans_ok;
  logic [NUM_STATES-1:0]   start_oh;
  logic [NUM_STATES-1:0]   pending;
  logic [NUM_STATES-1:0]   pick_oh;
  logic [SIDX-1:0]         pick_idx;
  logic [SYMBOL_BITS-1:0]  gsym;

  assign busy     = (state_r != ST_IDLE) || tbl_clr || alpha_clr;
  assign accept   = start && !busy;
  assign in_sym   = in_symbol[SYMBOL_BITS-1:0];
  assign trans_ok = (32'(in_from_state) < NUM_STATES) && (32'(in_to_state) < NUM_STATES);
  assign start_oh = (32'(start_state_r) < NUM_STATES) ?
                    (NUM_STATES'(1) << start_state_r) : '0;

  // worklist: states in the source set whose row is not yet merged
  always_comb begin
    pending  = ((phase_r == PH_STEP) ? src_r : set_r) & ~done_r;
    pick_oh  = pending & (~pending + 1'b1);
    pick_idx = '0;
    for (int i = NUM_STATES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick_idx = SIDX'(i);
      end
    end
    gsym = (phase_r == PH_STEP) ? sym_r : LAMBDA_SYM;
  end

  always_comb begin
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = {pick_idx, gsym};
    if (state_r == ST_IDLE) begin
      tbl_rd_en   = accept && (in_command == lnfa_pkg::CMD_ADD_TRANS) && trans_ok;
      tbl_rd_addr = {SIDX'(in_from_state), in_sym};
    end else if (state_r == ST_GATHER_ISSUE) begin
      tbl_rd_en = |pending;
    end
  end

  assign tbl_wr_en   = (state_r == ST_LOAD_WR);
  assign tbl_wr_data = tbl_rdata | to_oh_r;

  lnfa_tbl #(
    .ADDR_BITS (AW),
    .DATA_BITS (NUM_STATES)
  ) u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (tbl_rd_en),
    .rd_addr  (tbl_rd_addr),
    .rd_data  (tbl_rdata),
    .wr_en    (tbl_wr_en),
    .wr_addr  (waddr_r),
    .wr_data  (tbl_wr_data),
    .clearing (tbl_clr)
  );

  // alphabet map: read on a word symbol, held until the check
  assign alpha_rd_en = accept && (in_command == lnfa_pkg::CMD_WORD);
  assign alpha_wr_en = accept && (in_command == lnfa_pkg::CMD_ADD_SYM);

  lnfa_tbl #(
    .ADDR_BITS (SYMBOL_BITS),
    .DATA_BITS (1)
  ) u_alpha (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (alpha_rd_en),
    .rd_addr  (in_sym),
    .rd_data  (alpha_rdata),
    .wr_en    (alpha_wr_en),
    .wr_addr  (in_sym),
    .wr_data  (1'b1),
    .clearing (alpha_clr)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      accept_mask_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == lnfa_pkg::REG_START_STATE) begin
        start_state_r <= pwdata[3:0];
      end else begin
        accept_mask_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == lnfa_pkg::REG_ACCEPT_MASK) ? 32'(accept_mask_r)
                                                          : 32'(start_state_r);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_START;
      in_word_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_command)
              lnfa_pkg::CMD_ADD_TRANS: begin
                if (trans_ok) begin
                  waddr_r <= {SIDX'(in_from_state), in_sym};
                  to_oh_r <= NUM_STATES'(1) << in_to_state;
                  state_r <= ST_LOAD_WR;
                end
              end
              lnfa_pkg::CMD_WORD: begin
                sym_r  <= in_sym;
                last_r <= in_last;
                if (!in_word_r) begin
                  set_r   <= start_oh;
                  done_r  <= '0;
                  phase_r <= PH_START;
                  state_r <= ST_GATHER_ISSUE;
                end else begin
                  state_r <= ST_WORD_CHK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOAD_WR: begin
          state_r <= ST_IDLE;
        end
        ST_WORD_CHK: begin
          if ((set_r == '0) || !alpha_rdata) begin
            set_r   <= '0;
            state_r <= ST_FINISH;
          end else begin
            src_r   <= set_r;
            set_r   <= '0;
            done_r  <= '0;
            phase_r <= PH_STEP;
            state_r <= ST_GATHER_ISSUE;
          end
        end
        ST_GATHER_ISSUE: begin
          if (pending == '0) begin
            unique case (phase_r)
              PH_START: state_r <= ST_WORD_CHK;
              PH_STEP: begin
                phase_r <= PH_CLOSE;
                done_r  <= '0;
              end
              PH_CLOSE: state_r <= ST_FINISH;
              default: state_r <= ST_FINISH;
            endcase
          end else begin
            done_r  <= done_r | pick_oh;
            state_r <= ST_GATHER_WAIT;
          end
        end
        ST_GATHER_WAIT: begin
          set_r   <= set_r | tbl_rdata;
          state_r <= ST_GATHER_ISSUE;
        end
        ST_FINISH: begin
          in_word_r      <= !last_r;
          out_valid_r    <= last_r;
          out_accepted_r <= |(set_r & NUM_STATES'(accept_mask_r));
          state_r        <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_accepted_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_wait_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GATHER_WAIT) |-> $past(state_r == ST_GATHER_ISSUE))
    else $error("row merge without a read issued");

  a_no_access_clear: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_clr |-> (!tbl_rd_en && !tbl_wr_en))
    else $error("table accessed during clearing pass");

  a_word_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_word_r)
    else $error("word still open after its result");

endmodule
